// ----- rtl/core/ppu_pkg.sv -----
// Shared types and constants for the particle pool update block.
// Holds the pool size, request and result codes, the spawn offset table
// and the command and status structs between controller and datapath.
package ppu_pkg;

  localparam int PARTICLE_COUNT = 64;
  localparam int SLOT_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int LIFE_W = 16;
  localparam int RATE_W = 20;
  localparam int DT_W = 16;
  localparam int POS_W = 32;
  localparam int RAND_W = 7;
  localparam int OUT_SLOT_W = 6;
  localparam int RISE_W = RATE_W + DT_W - 12;
  localparam int OFF_W = 14;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 104;

  localparam logic [1:0] REQ_SPAWN = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_LIVE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_LIFE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RISE_RATE = 1'd1;

  localparam logic [LIFE_W-1:0] INITIAL_LIFE_RESET = 16'd4096;
  localparam logic [RATE_W-1:0] RISE_RATE_RESET = 20'd52429;

  typedef logic signed [OFF_W-1:0] off_table_t [2**RAND_W];

  // Offset (r-50)*65536/1000 rounded to nearest, built at elaboration.
  function automatic off_table_t build_off_table();
    off_table_t t;
    int n;
    for (int r = 0; r < 2**RAND_W; r++) begin
      n = (r - 50) * 65536;
      if (n >= 0) begin
        t[r] = OFF_W'((n + 500) / 1000);
      end else begin
        t[r] = OFF_W'(-((-n + 500) / 1000));
      end
    end
    return t;
  endfunction

  localparam off_table_t OFF_TABLE = build_off_table();

  typedef struct packed {
    logic load_req;
    logic idx_clr;
    logic idx_inc;
    logic pick;
    logic spawn_wr;
    logic mul_en;
    logic rd_en;
    logic tick_wb;
    logic pend_set;
    logic pend_clr;
    logic out_pend;
    logic out_last;
    logic out_none;
  } cmd_t;

  typedef struct packed {
    logic live_cur;
    logic idx_end;
    logic out_free;
    logic have_pend;
    logic cnt_last;
  } status_t;

endpackage

// ----- rtl/core/ppu_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ppu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ppu_ctrl.sv -----
// Controller state machine for the particle pool update block.
// Depends on ppu_pkg for the command and status structs and codes.
module ppu_ctrl
  import ppu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic [1:0]  s_tuser,
  input  status_t     status,
  output cmd_t        cmd,
  output logic        s_tready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPAWN_SCAN = 3'd1;
  localparam logic [2:0] S_SPAWN_WR = 3'd2;
  localparam logic [2:0] S_TICK_MUL = 3'd3;
  localparam logic [2:0] S_TICK_RUN = 3'd4;
  localparam logic [2:0] S_TICK_LAST = 3'd5;
  localparam logic [2:0] S_RD_SCAN = 3'd6;
  localparam logic [2:0] S_RD_FINAL = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.idx_clr = 1'b1;
          case (s_tuser)
            REQ_SPAWN: state_next = S_SPAWN_SCAN;
            REQ_TICK: state_next = S_TICK_MUL;
            REQ_READ: begin
              cmd.pend_clr = 1'b1;
              state_next = S_RD_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SPAWN_SCAN: begin
        if (!status.live_cur || status.idx_end) begin
          cmd.pick = 1'b1;
          state_next = S_SPAWN_WR;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SPAWN_WR: begin
        if (status.out_free) begin
          cmd.spawn_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_TICK_RUN;
      end
      S_TICK_RUN: begin
        cmd.rd_en = 1'b1;
        cmd.tick_wb = 1'b1;
        if (status.idx_end) begin
          state_next = S_TICK_LAST;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TICK_LAST: begin
        cmd.tick_wb = 1'b1;
        state_next = S_IDLE;
      end
      S_RD_SCAN: begin
        if (status.live_cur) begin
          if (!status.have_pend || status.out_free) begin
            cmd.out_pend = status.have_pend;
            cmd.rd_en = 1'b1;
            cmd.pend_set = 1'b1;
            if (status.idx_end || status.cnt_last) begin
              state_next = S_RD_FINAL;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end else if (status.idx_end) begin
          state_next = S_RD_FINAL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RD_FINAL: begin
        if (status.out_free) begin
          cmd.out_pend = status.have_pend;
          cmd.out_last = 1'b1;
          cmd.out_none = !status.have_pend;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ppu_datapath.sv -----
// Datapath of the particle pool update block: registers, pool memories,
// live flags, arithmetic and output register. Depends on ppu_pkg, ppu_ram.
module ppu_datapath
  import ppu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [IN_DATA_W-1:0]    s_tdata,
  input  cmd_t                    cmd,
  output status_t                 status,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_DATA_W-1:0]   m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PARTICLE_COUNT - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 1);
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic [LIFE_W-1:0] initial_life;
  logic [RATE_W-1:0] rise_rate;

  logic [DT_W-1:0] dt;
  logic signed [POS_W-1:0] emit_x;
  logic signed [POS_W-1:0] emit_y;
  logic signed [POS_W-1:0] emit_z;
  logic [RAND_W-1:0] rand_x;
  logic [RAND_W-1:0] rand_z;
  logic [RISE_W-1:0] rise;

  logic [PARTICLE_COUNT-1:0] live;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] spawn_slot;
  logic p_valid;
  logic [SLOT_W-1:0] p_addr;
  logic have_pend;
  logic [SLOT_W-1:0] pend_slot;
  logic [CNT_W-1:0] cnt;

  logic [1:0] out_kind;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic out_last;

  logic [LIFE_W-1:0] life_rdata;
  logic [POS_W-1:0] x_rdata;
  logic [POS_W-1:0] y_rdata;
  logic [POS_W-1:0] z_rdata;

  logic life_we;
  logic [SLOT_W-1:0] life_waddr;
  logic [LIFE_W-1:0] life_wdata;
  logic y_we;
  logic [SLOT_W-1:0] y_waddr;
  logic [POS_W-1:0] y_wdata;

  logic signed [POS_W:0] sx_sum;
  logic signed [POS_W:0] sz_sum;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_z;
  logic [LIFE_W-1:0] old_life;
  logic [LIFE_W-1:0] tick_life;
  logic signed [POS_W:0] ty_sum;
  logic [POS_W-1:0] tick_y;
  logic tick_act;
  logic [RATE_W+DT_W-1:0] product;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  assign status.live_cur = live[idx];
  assign status.idx_end = (idx == LAST_SLOT);
  assign status.out_free = out_free;
  assign status.have_pend = have_pend;
  assign status.cnt_last = (cnt == LAST_CNT);

  assign sx_sum = {emit_x[POS_W-1], emit_x} + (POS_W+1)'(OFF_TABLE[rand_x]);
  assign sz_sum = {emit_z[POS_W-1], emit_z} + (POS_W+1)'(OFF_TABLE[rand_z]);

  always_comb begin
    if (sx_sum[POS_W] != sx_sum[POS_W-1]) begin
      new_x = sx_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      new_x = sx_sum[POS_W-1:0];
    end
    if (sz_sum[POS_W] != sz_sum[POS_W-1]) begin
      new_z = sz_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      new_z = sz_sum[POS_W-1:0];
    end
  end

  assign product = RATE_W'(rise_rate) * DT_W'(dt);
  assign tick_act = cmd.tick_wb && p_valid;
  assign old_life = live[p_addr] ? life_rdata : '0;
  assign tick_life = (old_life > dt) ? old_life - dt : '0;
  assign ty_sum = {y_rdata[POS_W-1], y_rdata} + {{(POS_W+1-RISE_W){1'b0}}, rise};
  assign tick_y = (ty_sum[POS_W] != ty_sum[POS_W-1]) ? POS_MAX : ty_sum[POS_W-1:0];

  always_comb begin
    life_we = 1'b0;
    life_waddr = p_addr;
    life_wdata = tick_life;
    y_we = 1'b0;
    y_waddr = p_addr;
    y_wdata = tick_y;
    if (cmd.spawn_wr) begin
      life_we = 1'b1;
      life_waddr = spawn_slot;
      life_wdata = initial_life;
      y_we = 1'b1;
      y_waddr = spawn_slot;
      y_wdata = emit_y;
    end else if (tick_act) begin
      life_we = 1'b1;
      y_we = (tick_life != '0);
    end
  end

  ppu_ram #(.WIDTH(LIFE_W), .DEPTH(PARTICLE_COUNT)) u_life_ram (
    .clk(clk), .we(life_we), .waddr(life_waddr), .wdata(life_wdata),
    .re(cmd.rd_en), .raddr(idx), .rdata(life_rdata)
  );

  ppu_ram #(.WIDTH(POS_W), .DEPTH(PARTICLE_COUNT)) u_x_ram (
    .clk(clk), .we(cmd.spawn_wr), .waddr(spawn_slot), .wdata(new_x),
    .re(cmd.rd_en), .raddr(idx), .rdata(x_rdata)
  );

  ppu_ram #(.WIDTH(POS_W), .DEPTH(PARTICLE_COUNT)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(y_waddr), .wdata(y_wdata),
    .re(cmd.rd_en), .raddr(idx), .rdata(y_rdata)
  );

  ppu_ram #(.WIDTH(POS_W), .DEPTH(PARTICLE_COUNT)) u_z_ram (
    .clk(clk), .we(cmd.spawn_wr), .waddr(spawn_slot), .wdata(new_z),
    .re(cmd.rd_en), .raddr(idx), .rdata(z_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_life <= INITIAL_LIFE_RESET;
      rise_rate <= RISE_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_LIFE: initial_life <= cfg_data[LIFE_W-1:0];
        CFG_RISE_RATE: rise_rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      dt <= s_tdata[15:0];
      emit_x <= s_tdata[47:16];
      emit_y <= s_tdata[79:48];
      emit_z <= s_tdata[111:80];
      rand_x <= s_tdata[118:112];
      rand_z <= s_tdata[125:119];
    end
    if (cmd.mul_en) begin
      rise <= product[RATE_W+DT_W-1:12];
    end
    if (cmd.pick) begin
      spawn_slot <= live[idx] ? '0 : idx;
    end
    if (cmd.pend_set) begin
      pend_slot <= idx;
    end
    p_addr <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      idx <= '0;
      p_valid <= 1'b0;
      have_pend <= 1'b0;
      cnt <= '0;
    end else begin
      p_valid <= cmd.rd_en;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.spawn_wr) begin
        live[spawn_slot] <= (initial_life != '0);
      end else if (tick_act) begin
        live[p_addr] <= (tick_life != '0);
      end
      if (cmd.pend_clr) begin
        have_pend <= 1'b0;
        cnt <= '0;
      end else if (cmd.pend_set) begin
        have_pend <= 1'b1;
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.spawn_wr || cmd.out_pend || cmd.out_none) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spawn_wr) begin
      out_kind <= KIND_SPAWN;
      out_slot <= OUT_SLOT_W'(spawn_slot);
      out_x <= new_x;
      out_y <= emit_y;
      out_z <= new_z;
      out_last <= 1'b1;
    end else if (cmd.out_pend) begin
      out_kind <= KIND_LIVE;
      out_slot <= OUT_SLOT_W'(pend_slot);
      out_x <= x_rdata;
      out_y <= y_rdata;
      out_z <= z_rdata;
      out_last <= cmd.out_last;
    end else if (cmd.out_none) begin
      out_kind <= KIND_NONE;
      out_slot <= '0;
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {2'b00, out_z, out_y, out_x, out_slot};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// ----- rtl/core/particle_pool_update.sv -----
// Top level of the particle pool update block.
// Joins ppu_ctrl and ppu_datapath; depends on ppu_pkg.
//
//  channel  dir  handshake            payload
//  s        in   s_tvalid/s_tready    s_tuser kind of request, s_tdata fields
//  m        out  m_tvalid/m_tready    m_tuser kind, m_tdata fields, m_tlast
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// A spawn scans the live flags for the first free slot, taking slot 0 if none is free,
// then waits while the previous result still waits in the output register.
// A tick makes one pass of read and write-back over every slot.
// A readout scans the slots and stalls while a result waits and m_tready is low.
// Reset clears the live flags; no memory clearing pass is needed.
// One item is worked on at a time; s_tready is high only between items.
module particle_pool_update
  import ppu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // dt, emitter_x, emitter_y, emitter_z, rand_x, rand_z, zero fill
  input  logic [IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  logic [1:0]              s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // slot, pos_x, pos_y, pos_z, zero fill
  output logic [OUT_DATA_W-1:0]   m_tdata,
  // kind
  output logic [1:0]              m_tuser,
  output logic                    m_tlast,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cmd_t cmd;
  status_t status;

  ppu_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tuser(s_tuser),
    .status(status),
    .cmd(cmd),
    .s_tready(s_tready)
  );

  ppu_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tdata(s_tdata),
    .cmd(cmd),
    .status(status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule
